// ===== hw/rtl/rau_pkg.sv =====
// Shared types, constants and codes of the rational arithmetic unit.
package rau_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int PROD_W      = 2 * VALUE_WIDTH;
	localparam int CNT_W       = $clog2(PROD_W + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_RED = 3'd4
	} op_t;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_ZERO_DEN = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW = 2'd2;

	typedef struct packed {
		logic                   neg;
		logic [VALUE_WIDTH-1:0] mag;
	} smag_t;

	localparam smag_t ONE_S = '{neg: 1'b0, mag: VALUE_WIDTH'(1)};

	typedef struct packed {
		op_t   op;
		smag_t na;
		smag_t da;
		smag_t nb;
		smag_t db;
	} item_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic full;
		logic empty;
	} qctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_SUM,
		S_GCD,
		S_DIVN,
		S_DIVD,
		S_CHECK,
		S_HOLD
	} bstate_t;

endpackage

// ===== hw/rtl/rau_front.sv =====
// Front part: decode the operation and turn operands into sign and magnitude.
module rau_front (
	input  logic [2:0]         op,
	input  logic [31:0]        num_a,
	input  logic [31:0]        den_a,
	input  logic [31:0]        num_b,
	input  logic [31:0]        den_b,
	output rau_pkg::item_t     item
);

	function automatic rau_pkg::smag_t to_smag(input logic [31:0] raw);
		logic [rau_pkg::VALUE_WIDTH-1:0] m;
		rau_pkg::smag_t r;
		m     = raw[rau_pkg::VALUE_WIDTH-1:0];
		r.neg = m[rau_pkg::VALUE_WIDTH-1];
		r.mag = r.neg ? (~m + rau_pkg::VALUE_WIDTH'(1)) : m;
		return r;
	endfunction

	rau_pkg::smag_t nb_s;

	always_comb begin
		nb_s    = to_smag(num_b);
		item.na = to_smag(num_a);
		item.da = to_smag(den_a);
		item.db = to_smag(den_b);
		item.op = rau_pkg::OP_RED;
		unique case (op)
			rau_pkg::OP_ADD: item.op = rau_pkg::OP_ADD;
			rau_pkg::OP_SUB: item.op = rau_pkg::OP_SUB;
			rau_pkg::OP_MUL: item.op = rau_pkg::OP_MUL;
			rau_pkg::OP_DIV: item.op = rau_pkg::OP_DIV;
			default: item.op = rau_pkg::OP_RED;
		endcase
		// subtract is add with the second numerator negated
		if (item.op == rau_pkg::OP_SUB) begin
			nb_s.neg = ~nb_s.neg;
		end
		item.nb = nb_s;
	end

endmodule

// ===== hw/rtl/rau_queue.sv =====
// Short queue of decoded items between front and back parts.
module rau_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  rau_pkg::qctl_t  ctl_in,
	output rau_pkg::qctl_t  ctl_out,
	input  rau_pkg::item_t  wr_item,
	output rau_pkg::item_t  rd_item
);

	rau_pkg::item_t              slot_q [rau_pkg::QUEUE_DEPTH];
	logic [rau_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [rau_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [rau_pkg::QPTR_W:0]    count_q;
	logic                        do_push;
	logic                        do_pop;

	assign ctl_out.full  = (count_q == (rau_pkg::QPTR_W+1)'(rau_pkg::QUEUE_DEPTH));
	assign ctl_out.empty = (count_q == '0);
	assign ctl_out.push  = do_push;
	assign ctl_out.pop   = do_pop;
	assign do_push = ctl_in.push && !ctl_out.full;
	assign do_pop  = ctl_in.pop && !ctl_out.empty;
	assign rd_item = slot_q[rd_ptr_q];

	function automatic logic [rau_pkg::QPTR_W-1:0] bump(input logic [rau_pkg::QPTR_W-1:0] p);
		return (p == rau_pkg::QPTR_W'(rau_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

// ===== hw/rtl/rau_back.sv =====
// Back part: products, binary gcd, exact divisions, result register.
module rau_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  rau_pkg::item_t      q_item,
	output logic                q_pop,
	input  logic                pop,
	output logic                empty,
	output logic [31:0]         num_r,
	output logic [30:0]         den_r,
	output logic [1:0]          status
);

	localparam int VW = rau_pkg::VALUE_WIDTH;
	localparam int PW = rau_pkg::PROD_W;
	localparam int CW = rau_pkg::CNT_W;
	localparam logic [PW-1:0] HALF = PW'(1) << (VW - 1);

	rau_pkg::bstate_t state_q, state_d;
	rau_pkg::item_t   item_q;
	logic [1:0]       mcnt_q;
	logic [PW-1:0]    pmag_q [3];
	logic             pneg_q [3];
	logic [PW-1:0]    nmag_q, dmag_q, a_q, b_q, g_q, quo_q, rem_q, rn_q;
	logic             nneg_q, dneg_q;
	logic [CW-1:0]    k_q, dcnt_q;
	logic [31:0]      res_num_q, num_r_q;
	logic [30:0]      res_den_q, den_r_q;
	logic [1:0]       res_st_q, status_q;
	logic             out_valid_q;

	rau_pkg::smag_t   mx, my;
	logic [PW-1:0]    prod;
	logic [PW-1:0]    smag;
	logic             sneg;
	logic [PW:0]      rem_sh;
	logic             qbit;
	logic [PW-1:0]    rem_nx, quo_nx;
	logic             res_neg, res_over;
	logic             load_res;

	assign empty  = !out_valid_q;
	assign num_r  = num_r_q;
	assign den_r  = den_r_q;
	assign status = status_q;

	// multiplier operand selection
	always_comb begin
		unique case (mcnt_q)
			2'd0: begin
				mx = item_q.na;
				my = (item_q.op == rau_pkg::OP_MUL) ? item_q.nb :
				     (item_q.op == rau_pkg::OP_RED) ? rau_pkg::ONE_S : item_q.db;
			end
			2'd1: begin
				mx = item_q.nb;
				my = item_q.da;
			end
			default: begin
				mx = item_q.da;
				my = (item_q.op == rau_pkg::OP_DIV) ? item_q.nb :
				     (item_q.op == rau_pkg::OP_RED) ? rau_pkg::ONE_S : item_q.db;
			end
		endcase
		prod = PW'(mx.mag) * PW'(my.mag);
	end

	// numerator: signed sum of the cross products, or the first product alone
	always_comb begin
		smag = pmag_q[0];
		sneg = pneg_q[0];
		if (item_q.op == rau_pkg::OP_ADD || item_q.op == rau_pkg::OP_SUB) begin
			if (pneg_q[0] == pneg_q[1]) begin
				smag = pmag_q[0] + pmag_q[1];
				sneg = pneg_q[0];
			end else if (pmag_q[0] >= pmag_q[1]) begin
				smag = pmag_q[0] - pmag_q[1];
				sneg = pneg_q[0];
			end else begin
				smag = pmag_q[1] - pmag_q[0];
				sneg = pneg_q[1];
			end
		end
		if (smag == '0) begin
			sneg = 1'b0;
		end
	end

	// one restoring division step
	always_comb begin
		rem_sh = {rem_q, quo_q[PW-1]};
		qbit   = (rem_sh >= {1'b0, g_q});
		rem_nx = qbit ? PW'(rem_sh - {1'b0, g_q}) : rem_sh[PW-1:0];
		quo_nx = {quo_q[PW-2:0], qbit};
	end

	always_comb begin
		res_neg  = (rn_q != '0) && (nneg_q != dneg_q);
		res_over = (quo_q > HALF - 1'b1) || (res_neg ? (rn_q > HALF) : (rn_q > HALF - 1'b1));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rau_pkg::S_IDLE:  if (!q_empty) state_d = rau_pkg::S_MUL;
			rau_pkg::S_MUL:   if (mcnt_q == 2'd2) state_d = rau_pkg::S_SUM;
			rau_pkg::S_SUM:   state_d = (pmag_q[2] == '0) ? rau_pkg::S_HOLD : rau_pkg::S_GCD;
			rau_pkg::S_GCD:   if (a_q == '0) state_d = rau_pkg::S_DIVN;
			rau_pkg::S_DIVN:  if (dcnt_q == CW'(1)) state_d = rau_pkg::S_DIVD;
			rau_pkg::S_DIVD:  if (dcnt_q == CW'(1)) state_d = rau_pkg::S_CHECK;
			rau_pkg::S_CHECK: state_d = rau_pkg::S_HOLD;
			rau_pkg::S_HOLD:  if (!out_valid_q) state_d = rau_pkg::S_IDLE;
			default:          state_d = rau_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = (state_q == rau_pkg::S_IDLE) && !q_empty;
		load_res = (state_q == rau_pkg::S_HOLD) && !out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rau_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_res) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			num_r_q  <= res_num_q;
			den_r_q  <= res_den_q;
			status_q <= res_st_q;
		end
		unique case (state_q)
			rau_pkg::S_IDLE: begin
				item_q <= q_item;
				mcnt_q <= 2'd0;
			end
			rau_pkg::S_MUL: begin
				pmag_q[mcnt_q] <= prod;
				pneg_q[mcnt_q] <= (prod != '0) && (mx.neg != my.neg);
				mcnt_q         <= mcnt_q + 2'd1;
			end
			rau_pkg::S_SUM: begin
				nmag_q <= smag;
				nneg_q <= sneg;
				dmag_q <= pmag_q[2];
				dneg_q <= pneg_q[2];
				a_q    <= smag;
				b_q    <= pmag_q[2];
				k_q    <= '0;
				res_num_q <= (smag != '0) ? 32'd1 : 32'd0;
				res_den_q <= '0;
				res_st_q  <= rau_pkg::STAT_ZERO_DEN;
			end
			rau_pkg::S_GCD: begin
				if (a_q == '0) begin
					g_q    <= b_q << k_q;
					quo_q  <= nmag_q;
					rem_q  <= '0;
					dcnt_q <= CW'(PW);
				end else if (!a_q[0] && !b_q[0]) begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (a_q >= b_q) begin
					a_q <= a_q - b_q;
				end else begin
					b_q <= b_q - a_q;
				end
			end
			rau_pkg::S_DIVN: begin
				if (dcnt_q == CW'(1)) begin
					rn_q   <= quo_nx;
					quo_q  <= dmag_q;
					rem_q  <= '0;
					dcnt_q <= CW'(PW);
				end else begin
					quo_q  <= quo_nx;
					rem_q  <= rem_nx;
					dcnt_q <= dcnt_q - 1'b1;
				end
			end
			rau_pkg::S_DIVD: begin
				quo_q  <= quo_nx;
				rem_q  <= rem_nx;
				dcnt_q <= dcnt_q - 1'b1;
			end
			rau_pkg::S_CHECK: begin
				if (res_over) begin
					res_num_q <= '0;
					res_den_q <= '0;
					res_st_q  <= rau_pkg::STAT_OVERFLOW;
				end else begin
					res_num_q <= res_neg ? (32'd0 - rn_q[31:0]) : rn_q[31:0];
					res_den_q <= quo_q[30:0];
					res_st_q  <= rau_pkg::STAT_OK;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hw/rtl/rational_arithmetic_unit_core.sv =====
// Top level of the rational arithmetic unit: front, item queue and back part.
//
//   channel   direction  handshake          payload
//   input     in         push / full        op, num_a, den_a, num_b, den_b
//   result    out        pop / empty        num_r, den_r, status
//
// In the back part an item is taken from the queue, three products are formed
// on the shared multiplier, the sum is formed, binary gcd runs one step a cycle,
// two restoring divisions follow at one quotient bit a cycle, then the result
// is checked and loaded into the output register.
// An item with a zero denominator skips gcd and divisions.
// The queue takes up to two items while the back part is busy; full rises then.
// A finished result waits in the output register until popped; the back part
// holds the next result until that register is free. Reset clears all control.
module rational_arithmetic_unit_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  op,
	input  logic [31:0] num_a,
	input  logic [31:0] den_a,
	input  logic [31:0] num_b,
	input  logic [31:0] den_b,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] num_r,
	output logic [30:0] den_r,
	output logic [1:0]  status
);

	rau_pkg::item_t front_item;
	rau_pkg::item_t q_item;
	rau_pkg::qctl_t qctl_in;
	rau_pkg::qctl_t qctl_out;
	logic           back_pop;

	// decode and convert every arriving item
	rau_front u_front (
		.op    (op),
		.num_a (num_a),
		.den_a (den_a),
		.num_b (num_b),
		.den_b (den_b),
		.item  (front_item)
	);

	always_comb begin
		qctl_in.push  = push;
		qctl_in.pop   = back_pop;
		qctl_in.full  = 1'b0;
		qctl_in.empty = 1'b0;
	end

	assign full = qctl_out.full;

	// hold decoded items until the back part is free
	rau_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (qctl_in),
		.ctl_out (qctl_out),
		.wr_item (front_item),
		.rd_item (q_item)
	);

	// advance one item at a time through products, gcd and divisions
	rau_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (qctl_out.empty),
		.q_item  (q_item),
		.q_pop   (back_pop),
		.pop     (pop),
		.empty   (empty),
		.num_r   (num_r),
		.den_r   (den_r),
		.status  (status)
	);

endmodule
